// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands used by the checker file brbf_chk
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/brbf_pkg.sv -----
// ----------------------------------------------------------------------------
// brbf_pkg
// types, codes and helpers of the circular byte fifo
// ----------------------------------------------------------------------------
package brbf_pkg;

	localparam int CNT_W      = 11;
	localparam int CNT_MAX    = 2047;
	localparam int LEN_W      = 7;
	localparam int BYTE_W     = 8;
	localparam int CMD_W      = 2;
	localparam int STAT_W     = 2;

	localparam int STORE_DEPTH_DEF = 1024;
	localparam int MAX_BLOCK_DEF   = 64;
	localparam int SIZE_RESET      = 1024;

	localparam int OQ_DEPTH = 4;
	localparam int OQ_IW    = 2;
	localparam int OQ_CW    = 3;

	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOSPACE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NODATA  = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [LEN_W-1:0]  block_len;
		logic              first_of_block;
		logic [BYTE_W-1:0] data_byte;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [BYTE_W-1:0] read_byte;
		logic              last;
		logic [CNT_W-1:0]  fill_count;
		logic              is_empty;
		logic              is_full;
	} rsp_t;

	// size in use: zero counts as one, capped at the store depth
	function automatic logic [CNT_W-1:0] eff_size(input logic [CNT_W-1:0] bs,
			input logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] s;
		s = bs;
		if (s == '0) begin
			s = CNT_W'(1);
		end
		if (s > cap) begin
			s = cap;
		end
		return s;
	endfunction

endpackage

// ----- rtl/core/brbf_outq.sv -----
// ----------------------------------------------------------------------------
// brbf_outq
// small result queue in front of the output channel, reports occupancy
// ----------------------------------------------------------------------------
module brbf_outq import brbf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rsp_t             push_data,
	output logic [OQ_CW-1:0] occ,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp
);

	rsp_t             ent_q [OQ_DEPTH];
	logic [OQ_IW-1:0] wp_q;
	logic [OQ_IW-1:0] rp_q;
	logic [OQ_CW-1:0] cnt_q;
	logic             pop;

	assign rsp_valid = (cnt_q != '0);
	assign rsp       = ent_q[rp_q];
	assign pop       = rsp_valid && !rsp_stall;
	assign occ       = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + OQ_IW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + OQ_IW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + OQ_CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - OQ_CW'(1);
			end
		end
	end

endmodule

// ----- rtl/core/byte_ring_buffer_block_fifo.sv -----
// ----------------------------------------------------------------------------
// byte_ring_buffer_block_fifo
// circular byte fifo with all-or-nothing write blocks and checked reads
//
//   channel   signals                         dir   carries
//   request   req_valid / req_stall / req     in    command, length, byte
//   result    rsp_valid / rsp_stall / rsp     out   status, byte, counts
//   config    cfg_wr_en / cfg_wr_data         in    buffer size
//
// write, clear and refused or empty reads: a single result each, queued as the request is taken
// an accepted read of n bytes stalls the request channel until its last byte is queued,
// one byte a cycle through the single read port of the byte store
// result stall slows reads through the four-entry result queue
// reset empties the fifo and sets the size to 1024; store contents undefined
// ----------------------------------------------------------------------------
module byte_ring_buffer_block_fifo import brbf_pkg::*; #(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF,
	parameter int MAX_BLOCK   = MAX_BLOCK_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp,
	input  logic             cfg_wr_en,
	input  logic [CNT_W-1:0] cfg_wr_data
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int WW = ((AW + 1) > CNT_W) ? (AW + 1) : CNT_W;
	localparam logic [CNT_W-1:0] DEPTH_CAP =
		CNT_W'((STORE_DEPTH > CNT_MAX) ? CNT_MAX : STORE_DEPTH);
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BLOCK);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	logic [BYTE_W-1:0] store_mem [STORE_DEPTH];

	logic             state_q, state_d;
	logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
	logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] eff_q;
	logic [LEN_W-1:0] wrem_q, wrem_d;
	logic             refused_q, refused_d;
	logic [LEN_W-1:0] rem_q, rem_d;

	logic              vld_s1;
	logic              last_s1;
	logic [CNT_W-1:0]  cnt_s1;
	logic              full_s1;
	logic [BYTE_W-1:0] rd_data_s1;

	logic [OQ_CW-1:0] occ;
	logic             accept;
	logic             issue;
	logic             mem_we;
	logic             do_store;
	logic             push_now;
	logic             push;
	logic [STAT_W-1:0] st;
	logic [LEN_W-1:0] len_c;
	logic [LEN_W-1:0] blen;
	logic [WW-1:0]    wr_nx_w;
	logic [WW-1:0]    rd_nx_w;
	logic [AW-1:0]    wr_ptr_nx;
	logic [AW-1:0]    rd_ptr_nx;
	rsp_t             push_data;

	assign req_stall = (state_q != ST_IDLE) || vld_s1 || (occ >= OQ_CW'(OQ_DEPTH));
	assign accept    = req_valid && !req_stall;
	assign issue     = (state_q == ST_READ) &&
		(({1'b0, occ} + (OQ_CW + 1)'(vld_s1)) < (OQ_CW + 1)'(OQ_DEPTH));

	assign len_c = (req.block_len > MAX_LEN) ? MAX_LEN : req.block_len;

	assign wr_nx_w   = WW'(wr_ptr_q) + WW'(1);
	assign rd_nx_w   = WW'(rd_ptr_q) + WW'(1);
	assign wr_ptr_nx = (wr_nx_w >= WW'(eff_q)) ? '0 : AW'(wr_nx_w);
	assign rd_ptr_nx = (rd_nx_w >= WW'(eff_q)) ? '0 : AW'(rd_nx_w);

	always_comb begin
		state_d   = state_q;
		wr_ptr_d  = wr_ptr_q;
		rd_ptr_d  = rd_ptr_q;
		cnt_d     = cnt_q;
		wrem_d    = wrem_q;
		refused_d = refused_q;
		rem_d     = rem_q;
		st        = STAT_OK;
		do_store  = 1'b0;
		push_now  = 1'b0;
		blen      = '0;
		if (accept) begin
			case (req.command)
				CMD_WRITE: begin
					push_now = 1'b1;
					if (!req.first_of_block && (wrem_q != '0)) begin
						wrem_d = wrem_q - LEN_W'(1);
						if (refused_q || (cnt_q >= eff_q)) begin
							st = STAT_NOSPACE;
						end else begin
							do_store = 1'b1;
						end
						if (wrem_d == '0) begin
							refused_d = 1'b0;
						end
					end else begin
						blen      = req.first_of_block ? len_c : LEN_W'(1);
						wrem_d    = '0;
						refused_d = 1'b0;
						if (blen != '0) begin
							if (CNT_W'(blen) > (eff_q - cnt_q)) begin
								st        = STAT_NOSPACE;
								refused_d = (blen > LEN_W'(1));
							end else if (cnt_q >= eff_q) begin
								st = STAT_NOSPACE;
							end else begin
								do_store = 1'b1;
							end
							wrem_d = blen - LEN_W'(1);
						end
					end
				end
				CMD_READ: begin
					if (CNT_W'(len_c) > cnt_q) begin
						push_now = 1'b1;
						st       = STAT_NODATA;
					end else if (len_c == '0) begin
						push_now = 1'b1;
					end else begin
						state_d = ST_READ;
						rem_d   = len_c;
					end
				end
				CMD_CLEAR: begin
					push_now  = 1'b1;
					wr_ptr_d  = '0;
					rd_ptr_d  = '0;
					cnt_d     = '0;
					wrem_d    = '0;
					refused_d = 1'b0;
				end
				default: begin
					push_now = 1'b1;
				end
			endcase
			if (do_store) begin
				wr_ptr_d = wr_ptr_nx;
				cnt_d    = cnt_q + CNT_W'(1);
			end
		end
		if (issue) begin
			rd_ptr_d = rd_ptr_nx;
			cnt_d    = cnt_q - CNT_W'(1);
			rem_d    = rem_q - LEN_W'(1);
			if (rem_q == LEN_W'(1)) begin
				state_d = ST_IDLE;
			end
		end
	end

	assign mem_we = do_store;
	assign push   = push_now || vld_s1;

	always_comb begin
		push_data = '0;
		if (vld_s1) begin
			push_data.status     = STAT_OK;
			push_data.read_byte  = rd_data_s1;
			push_data.last       = last_s1;
			push_data.fill_count = cnt_s1;
			push_data.is_empty   = (cnt_s1 == '0);
			push_data.is_full    = full_s1;
		end else begin
			push_data.status     = st;
			push_data.last       = 1'b1;
			push_data.fill_count = cnt_d;
			push_data.is_empty   = (cnt_d == '0);
			push_data.is_full    = (cnt_d == eff_q);
		end
	end

	// byte store, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[wr_ptr_q] <= req.data_byte;
		end
		if (issue) begin
			rd_data_s1 <= store_mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			last_s1 <= (rem_q == LEN_W'(1));
			cnt_s1  <= cnt_d;
			full_s1 <= (cnt_d == eff_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			cnt_q     <= '0;
			eff_q     <= eff_size(CNT_W'(SIZE_RESET), DEPTH_CAP);
			wrem_q    <= '0;
			refused_q <= 1'b0;
			rem_q     <= '0;
			vld_s1    <= 1'b0;
		end else if (cfg_wr_en) begin
			state_q   <= ST_IDLE;
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			cnt_q     <= '0;
			eff_q     <= eff_size(cfg_wr_data, DEPTH_CAP);
			wrem_q    <= '0;
			refused_q <= 1'b0;
			rem_q     <= '0;
			vld_s1    <= 1'b0;
		end else begin
			state_q   <= state_d;
			wr_ptr_q  <= wr_ptr_d;
			rd_ptr_q  <= rd_ptr_d;
			cnt_q     <= cnt_d;
			wrem_q    <= wrem_d;
			refused_q <= refused_d;
			rem_q     <= rem_d;
			vld_s1    <= issue;
		end
	end

	brbf_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.occ       (occ),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ----- rtl/core/brbf_chk.sv -----
// ----------------------------------------------------------------------------
// brbf_chk
// port-level checks of the circular byte fifo, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module brbf_chk import brbf_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_stall,
	input req_t             req,
	input logic             rsp_valid,
	input logic             rsp_stall,
	input rsp_t             rsp,
	input logic             cfg_wr_en,
	input logic [CNT_W-1:0] cfg_wr_data
);

	logic unused_in;
	assign unused_in = req_valid ^ req_stall ^ (^req) ^ cfg_wr_en ^ (^cfg_wr_data);

	`ASSERT_SAME(a_empty_flag, clk, arst_n, rsp_valid, rsp.is_empty == (rsp.fill_count == '0), "empty flag disagrees with fill count")
	`ASSERT_SAME(a_refused_single, clk, arst_n, rsp_valid && (rsp.status != STAT_OK), rsp.last && (rsp.read_byte == '0), "refused request gave more than one plain result")
	`ASSERT_SAME(a_full_not_empty, clk, arst_n, rsp_valid && rsp.is_full, !rsp.is_empty && (rsp.fill_count != '0), "full and empty together")
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result changed")

endmodule

bind byte_ring_buffer_block_fifo brbf_chk u_brbf_chk (.*);

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// regression for the circular byte fifo: a directed table of requests
// (empty and refused reads, zero-length and refused write blocks, abandoned
// blocks, size extremes) followed by random write blocks, reads, clears and
// noise under several buffer sizes, with idle cycles on both sides in the first four; every
// result is checked against a cycle-free prediction of the fifo
// ----------------------------------------------------------------------------
module testbench;
	import brbf_pkg::*;

	localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct {
		int   cfg;
		req_t r;
		bit   typed;
		rsp_t want;
	} fifo_row_t;

	logic             clk;
	logic             arst_n;
	logic             req_valid;
	logic             req_stall;
	req_t             req;
	logic             rsp_valid;
	logic             rsp_stall;
	rsp_t             rsp;
	logic             cfg_wr_en;
	logic [CNT_W-1:0] cfg_wr_data;

	// fifo prediction state
	logic [BYTE_W-1:0] fifo_mem [0:STORE_DEPTH_DEF-1];
	logic [9:0]        wr_ptr;
	logic [9:0]        rd_ptr;
	logic [CNT_W-1:0]  fill;
	logic [LEN_W-1:0]  blk_left;
	logic              blk_refused;
	logic [CNT_W-1:0]  size_reg;

	rsp_t      fifo_results_due [$];
	fifo_row_t directed_rows [$];

	int unsigned mismatch_count;
	int unsigned cycle_count;
	int unsigned requests_sent;
	int unsigned requests_taken;
	int unsigned req_idle_pct;
	int unsigned rsp_stall_pct;
	bit          use_typed;
	rsp_t        typed_rsp;

	byte_ring_buffer_block_fifo DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int size_in_use();
		if (size_reg == '0) begin
			return 1;
		end
		if (size_reg > CNT_W'(STORE_DEPTH_DEF)) begin
			return STORE_DEPTH_DEF;
		end
		return int'(size_reg);
	endfunction

	function automatic logic [9:0] advance_ptr(input logic [9:0] p);
		return (int'(p) + 1 >= size_in_use()) ? 10'd0 : p + 10'd1;
	endfunction

	function automatic void empty_fifo_state();
		wr_ptr = '0;
		rd_ptr = '0;
		fill = '0;
		blk_left = '0;
		blk_refused = 1'b0;
	endfunction

	function automatic void push_fifo_result(input logic [STAT_W-1:0] st,
			input logic [BYTE_W-1:0] b, input logic last);
		rsp_t x;
		x.status = st;
		x.read_byte = b;
		x.last = last;
		x.fill_count = fill;
		x.is_empty = (fill == '0);
		x.is_full = (int'(fill) == size_in_use());
		fifo_results_due.push_back(x);
	endfunction

	function automatic logic [STAT_W-1:0] store_fifo_byte(input logic [BYTE_W-1:0] b);
		if (int'(fill) >= size_in_use()) begin
			return STAT_NOSPACE;
		end
		fifo_mem[wr_ptr] = b;
		wr_ptr = advance_ptr(wr_ptr);
		fill = fill + 1'b1;
		return STAT_OK;
	endfunction

	function automatic void compute_fifo_results(input req_t r);
		logic [LEN_W-1:0]  len;
		logic [STAT_W-1:0] st;
		int                l;
		len = (r.block_len > LEN_W'(MAX_BLOCK_DEF)) ? LEN_W'(MAX_BLOCK_DEF) : r.block_len;
		st = STAT_OK;
		case (r.command)
			CMD_WRITE: begin
				if (!r.first_of_block && blk_left != '0) begin
					blk_left = blk_left - 1'b1;
					st = blk_refused ? STAT_NOSPACE : store_fifo_byte(r.data_byte);
					if (blk_left == '0) begin
						blk_refused = 1'b0;
					end
				end else begin
					l = r.first_of_block ? int'(len) : 1;
					blk_left = '0;
					blk_refused = 1'b0;
					if (l != 0) begin
						if (l > size_in_use() - int'(fill)) begin
							st = STAT_NOSPACE;
							blk_refused = (l > 1);
						end else begin
							st = store_fifo_byte(r.data_byte);
						end
						blk_left = LEN_W'(l - 1);
					end
				end
				push_fifo_result(st, '0, 1'b1);
			end
			CMD_READ: begin
				if (len > fill) begin
					push_fifo_result(STAT_NODATA, '0, 1'b1);
				end else if (len == '0) begin
					push_fifo_result(STAT_OK, '0, 1'b1);
				end else begin
					for (int i = 0; i < int'(len); i++) begin
						st = STAT_OK;
						fill = fill - 1'b1;
						push_fifo_result(st, fifo_mem[rd_ptr], (i + 1 == int'(len)));
						rd_ptr = advance_ptr(rd_ptr);
					end
				end
			end
			CMD_CLEAR: begin
				empty_fifo_state();
				push_fifo_result(STAT_OK, '0, 1'b1);
			end
			default: begin
				push_fifo_result(STAT_OK, '0, 1'b1);
			end
		endcase
	endfunction

	function automatic void check_fifo_result(input rsp_t got);
		rsp_t want;
		if (fifo_results_due.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10) begin
				$display("unexpected result: status=%0d byte=%h last=%b fill=%0d empty=%b full=%b",
					got.status, got.read_byte, got.last, got.fill_count, got.is_empty,
					got.is_full);
			end
			return;
		end
		want = fifo_results_due.pop_front();
		if (got.status !== want.status || got.read_byte !== want.read_byte
				|| got.last !== want.last || got.fill_count !== want.fill_count
				|| got.is_empty !== want.is_empty || got.is_full !== want.is_full) begin
			mismatch_count++;
			if (mismatch_count <= 10) begin
				$display("result mismatch: got status=%0d byte=%h last=%b fill=%0d empty=%b full=%b",
					got.status, got.read_byte, got.last, got.fill_count, got.is_empty,
					got.is_full);
				$display("                 exp status=%0d byte=%h last=%b fill=%0d empty=%b full=%b",
					want.status, want.read_byte, want.last, want.fill_count, want.is_empty,
					want.is_full);
			end
		end
	endfunction

	// request acceptance is predicted before the result at the same edge is checked
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				compute_fifo_results(req);
				if (use_typed) begin
					fifo_results_due[fifo_results_due.size() - 1] = typed_rsp;
				end
				requests_taken++;
			end
			if (rsp_valid && !rsp_stall) begin
				check_fifo_result(rsp);
			end
		end
	end

	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("byte_ring_buffer_block_fifo regression: fail");
			$finish;
		end
	end

	function automatic req_t make_req(input logic [CMD_W-1:0] c, input int len,
			input logic first, input logic [BYTE_W-1:0] d);
		req_t r;
		r.command = c;
		r.block_len = LEN_W'(len);
		r.first_of_block = first;
		r.data_byte = d;
		return r;
	endfunction

	function automatic void add_row(input int cfg, input req_t r, input bit typed,
			input logic [STAT_W-1:0] st, input int cnt, input bit full);
		fifo_row_t row;
		row.cfg = cfg;
		row.r = r;
		row.typed = typed;
		row.want.status = st;
		row.want.read_byte = '0;
		row.want.last = 1'b1;
		row.want.fill_count = CNT_W'(cnt);
		row.want.is_empty = (cnt == 0);
		row.want.is_full = full;
		directed_rows.push_back(row);
	endfunction

	task automatic send_request(input req_t r, input bit typed, input rsp_t want);
		while ($urandom_range(0, 99) < req_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		use_typed = typed;
		typed_rsp = want;
		req_valid <= 1'b1;
		req <= r;
		requests_sent++;
		wait (requests_taken == requests_sent);
		use_typed = 1'b0;
	endtask

	task automatic send_random(input req_t r);
		send_request(r, 1'b0, '0);
	endtask

	task automatic configure_size(input int v);
		req_valid <= 1'b0;
		while (fifo_results_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= CNT_W'(v);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		size_reg = CNT_W'(v);
		empty_fifo_state();
	endtask

	task automatic random_segment(input int n_items);
		int sent;
		int pick;
		int len;
		int body;
		int free_bytes;
		int hi;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				free_bytes = size_in_use() - int'(fill);
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					len = $urandom_range(1, 8);
				end else if (pick < 80) begin
					len = $urandom_range(9, MAX_BLOCK_DEF);
				end else if (pick < 90) begin
					len = (free_bytes >= 1 && free_bytes <= MAX_BLOCK_DEF) ? free_bytes : 1;
				end else if (pick < 95) begin
					len = 0;
				end else begin
					len = $urandom_range(MAX_BLOCK_DEF + 1, 127);
				end
				send_random(make_req(CMD_WRITE, len, 1'b1, BYTE_W'($urandom)));
				sent++;
				body = (len > MAX_BLOCK_DEF) ? MAX_BLOCK_DEF - 1 : ((len > 0) ? len - 1 : 0);
				if (body > 0 && $urandom_range(0, 99) < 10) begin
					body = $urandom_range(0, body - 1);
				end
				for (int i = 0; i < body; i++) begin
					send_random(make_req(CMD_WRITE, $urandom_range(0, 127), 1'b0,
						BYTE_W'($urandom)));
					sent++;
				end
			end else begin
				if (pick < 75) begin
					hi = (int'(fill) < MAX_BLOCK_DEF) ? int'(fill) : MAX_BLOCK_DEF;
					len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, hi)
						: $urandom_range(0, 127);
					send_random(make_req(CMD_READ, len, 1'($urandom), BYTE_W'($urandom)));
				end else if (pick < 85) begin
					send_random(make_req(CMD_WRITE, $urandom_range(0, 127), 1'b0,
						BYTE_W'($urandom)));
				end else if (pick < 90) begin
					send_random(make_req(CMD_CLEAR, $urandom_range(0, 127), 1'($urandom),
						BYTE_W'($urandom)));
				end else if (pick < 95) begin
					send_random(make_req(CMD_NOP, $urandom_range(0, 127), 1'($urandom),
						BYTE_W'($urandom)));
				end else begin
					send_random(make_req(CMD_W'($urandom), $urandom_range(0, 127),
						1'($urandom), BYTE_W'($urandom)));
				end
				sent++;
			end
		end
	endtask

	initial begin
		int segment_sizes [6];
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		rsp_stall <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		mismatch_count = 0;
		cycle_count = 0;
		requests_sent = 0;
		requests_taken = 0;
		use_typed = 1'b0;
		typed_rsp = '0;
		for (int i = 0; i < STORE_DEPTH_DEF; i++) begin
			fifo_mem[i] = '0;
		end
		size_reg = CNT_W'(SIZE_RESET);
		empty_fifo_state();
		segment_sizes = '{5, 1024, 1, 13, 2047, 40};
		req_idle_pct = 16;
		rsp_stall_pct = 73;

		// size 1024 after reset
		add_row(-1, make_req(CMD_READ, 1, 1'b0, 8'h00), 1, STAT_NODATA, 0, 0);
		add_row(-1, make_req(CMD_READ, 0, 1'b1, 8'hFF), 1, STAT_OK, 0, 0);
		add_row(-1, make_req(CMD_CLEAR, 127, 1'b1, 8'h55), 1, STAT_OK, 0, 0);
		add_row(-1, make_req(CMD_NOP, 0, 1'b0, 8'h00), 1, STAT_OK, 0, 0);
		add_row(-1, make_req(CMD_WRITE, 0, 1'b1, 8'hFF), 1, STAT_OK, 0, 0);
		add_row(-1, make_req(CMD_WRITE, 0, 1'b0, 8'hA5), 1, STAT_OK, 1, 0);
		add_row(-1, make_req(CMD_WRITE, 3, 1'b1, 8'h00), 0, STAT_OK, 0, 0);
		add_row(-1, make_req(CMD_WRITE, 127, 1'b0, 8'hFF), 0, STAT_OK, 0, 0);
		add_row(-1, make_req(CMD_WRITE, 2, 1'b1, 8'h5A), 0, STAT_OK, 0, 0);
		add_row(-1, make_req(CMD_WRITE, 0, 1'b0, 8'h81), 0, STAT_OK, 0, 0);
		add_row(-1, make_req(CMD_READ, 5, 1'b0, 8'h00), 0, STAT_OK, 0, 0);
		add_row(-1, make_req(CMD_WRITE, 127, 1'b1, 8'h7F), 0, STAT_OK, 0, 0);
		add_row(-1, make_req(CMD_READ, 127, 1'b0, 8'h00), 1, STAT_NODATA, 1, 0);
		add_row(-1, make_req(CMD_READ, 1, 1'b0, 8'h00), 0, STAT_OK, 0, 0);
		// size 2: refused block and full buffer
		add_row(2, make_req(CMD_WRITE, 3, 1'b1, 8'h11), 1, STAT_NOSPACE, 0, 0);
		add_row(-1, make_req(CMD_WRITE, 0, 1'b0, 8'h22), 1, STAT_NOSPACE, 0, 0);
		add_row(-1, make_req(CMD_WRITE, 0, 1'b0, 8'h33), 1, STAT_NOSPACE, 0, 0);
		add_row(-1, make_req(CMD_WRITE, 2, 1'b1, 8'hC3), 0, STAT_OK, 0, 0);
		add_row(-1, make_req(CMD_WRITE, 0, 1'b0, 8'h3C), 0, STAT_OK, 0, 0);
		add_row(-1, make_req(CMD_WRITE, 0, 1'b0, 8'h99), 1, STAT_NOSPACE, 2, 1);
		add_row(-1, make_req(CMD_READ, 2, 1'b0, 8'h00), 0, STAT_OK, 0, 0);
		// size zero behaves as one
		add_row(0, make_req(CMD_WRITE, 0, 1'b0, 8'h01), 1, STAT_OK, 1, 1);
		add_row(-1, make_req(CMD_WRITE, 1, 1'b1, 8'h02), 1, STAT_NOSPACE, 1, 1);
		add_row(-1, make_req(CMD_READ, 1, 1'b0, 8'h00), 0, STAT_OK, 0, 0);
		// oversize register caps at the store depth
		add_row(2047, make_req(CMD_WRITE, 64, 1'b1, 8'hE7), 0, STAT_OK, 0, 0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].cfg >= 0) begin
				configure_size(directed_rows[i].cfg);
			end
			send_request(directed_rows[i].r, directed_rows[i].typed, directed_rows[i].want);
		end

		for (int seg = 0; seg < 6; seg++) begin
			if (seg == 2) begin
				req_idle_pct = 73;
				rsp_stall_pct = 16;
			end else if (seg == 4) begin
				req_idle_pct = 0;
				rsp_stall_pct = 0;
			end
			configure_size(segment_sizes[seg]);
			random_segment(35);
		end

		req_valid <= 1'b0;
		while (fifo_results_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("byte_ring_buffer_block_fifo regression: pass");
		end else begin
			$display("byte_ring_buffer_block_fifo regression: fail");
		end
		$finish;
	end

endmodule
